FILE: rtl/transient_suppressor_macros.svh
// ----------------------------------------------------------------------------
// Transient suppressor assertion macros
// Short forms for clocked assertions sampled on aclk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRANSIENT_SUPPRESSOR_MACROS_SVH
`define TRANSIENT_SUPPRESSOR_MACROS_SVH

// Consequent checked at the same edge as the antecedent.
`define TSUP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked at the edge after the antecedent.
`define TSUP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tsup_pkg.sv
// ----------------------------------------------------------------------------
// Transient suppressor package
// Widths, register indexes and shared types of the transient suppressor.
// ----------------------------------------------------------------------------
`default_nettype none

package tsup_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ENV_W       = SAMPLE_BITS + 8;    // Q(SAMPLE_BITS).8 envelope
    localparam int CMP_W       = ENV_W + 20;         // room for fast << 20
    localparam int COEF_W      = 16;
    localparam int GAIN_W      = 17;
    localparam int HOLD_W      = 20;
    localparam int THR_W       = 16;
    localparam int MINLVL_W    = 23;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 23;
    localparam int FRAC_BITS   = 16;

    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = (ENV_W > GAIN_W) ? ENV_W : GAIN_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN   = GAIN_W'(65536);
    localparam logic [COEF_W-1:0]  ATTACK_COEFF = COEF_W'(62862);
    localparam logic [THR_W-1:0]   THR_UNITY    = THR_W'(256);
    localparam logic [MUL_P_W-1:0] ROUND_UP     = MUL_P_W'(65535);
    localparam logic [ENV_W-1:0]   SLOW_FLOOR   =
        ENV_W'(((64'd1 << (SAMPLE_BITS - 1)) >> 20) << 8);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_COEF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_COEF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REL_COEF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ATTEN     = 3'd7;

    typedef struct packed {
        logic                  enable;
        logic [COEF_W-1:0]     fast_coeff;
        logic [COEF_W-1:0]     slow_coeff;
        logic [COEF_W-1:0]     release_coeff;
        logic [HOLD_W-1:0]     hold_samples;
        logic [THR_W-1:0]      threshold_ratio;
        logic [MINLVL_W-1:0]   min_level;
        logic [GAIN_W-1:0]     attenuation_gain;
    } cfg_t;

    typedef struct packed {
        logic                  issue;
        logic [MUL_A_W-1:0]    a;
        logic [MUL_B_W-1:0]    b;
    } mul_req_t;

endpackage

`default_nettype wire

FILE: rtl/tsup_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 17 x envelope-width multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module tsup_mul (
    input  wire                            aclk,
    input  wire tsup_pkg::mul_req_t        req,
    output logic [tsup_pkg::MUL_P_W-1:0]   prod_reg
);

    logic [tsup_pkg::MUL_P_W-1:0] prod_next;

    assign prod_next = tsup_pkg::MUL_P_W'(req.a) * tsup_pkg::MUL_P_W'(req.b);

    // Hold the product until the sequencer issues the next request.
    always_ff @(posedge aclk) begin
        if (req.issue) begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tsup_cfg.sv
// ----------------------------------------------------------------------------
// Transient suppressor configuration registers
// Holds the eight control registers written through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module tsup_cfg (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_valid,
    input  wire  [tsup_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [tsup_pkg::CFG_DATA_W-1:0]   cfg_data,
    output tsup_pkg::cfg_t                    cfg,
    output logic                              gain_unity
);

    tsup_pkg::cfg_t cfg_reg;
    tsup_pkg::cfg_t cfg_next;

    assign cfg = cfg_reg;

    // Clearing enable snaps the gain back to unity.
    assign gain_unity = cfg_valid && (cfg_index == tsup_pkg::REG_ENABLE) && !cfg_data[0];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                tsup_pkg::REG_ENABLE:    cfg_next.enable = cfg_data[0];
                tsup_pkg::REG_FAST_COEF: cfg_next.fast_coeff = cfg_data[tsup_pkg::COEF_W-1:0];
                tsup_pkg::REG_SLOW_COEF: cfg_next.slow_coeff = cfg_data[tsup_pkg::COEF_W-1:0];
                tsup_pkg::REG_REL_COEF: begin
                    cfg_next.release_coeff = cfg_data[tsup_pkg::COEF_W-1:0];
                end
                tsup_pkg::REG_HOLD:      cfg_next.hold_samples = cfg_data[tsup_pkg::HOLD_W-1:0];
                tsup_pkg::REG_THRESHOLD: begin
                    cfg_next.threshold_ratio = cfg_data[tsup_pkg::THR_W-1:0];
                end
                tsup_pkg::REG_MIN_LEVEL: cfg_next.min_level = cfg_data[tsup_pkg::MINLVL_W-1:0];
                tsup_pkg::REG_ATTEN: begin
                    cfg_next.attenuation_gain = cfg_data[tsup_pkg::GAIN_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable           <= 1'b1;
            cfg_reg.fast_coeff       <= tsup_pkg::COEF_W'(64185);
            cfg_reg.slow_coeff       <= tsup_pkg::COEF_W'(65522);
            cfg_reg.release_coeff    <= tsup_pkg::COEF_W'(65522);
            cfg_reg.hold_samples     <= '0;
            cfg_reg.threshold_ratio  <= tsup_pkg::THR_W'(1019);
            cfg_reg.min_level        <= tsup_pkg::MINLVL_W'(8389);
            cfg_reg.attenuation_gain <= tsup_pkg::GAIN_W'(16462);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tsup_core.sv
// ----------------------------------------------------------------------------
// Transient suppressor sequencer and datapath
// Steps one sample through envelopes, trigger, gain and output multiply, or bypasses them.
// ----------------------------------------------------------------------------
`default_nettype none

module tsup_core (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire tsup_pkg::cfg_t                cfg,
    input  wire                                gain_unity,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [tsup_pkg::SAMPLE_BITS-1:0]   s_sample,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [tsup_pkg::SAMPLE_BITS-1:0]   m_sample,
    output logic                               m_supp,
    output tsup_pkg::mul_req_t                 mul_req,
    input  wire  [tsup_pkg::MUL_P_W-1:0]       mul_prod
);

    localparam int SB = tsup_pkg::SAMPLE_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FAST_A,
        ST_FAST_B,
        ST_SLOW_A,
        ST_SLOW_B,
        ST_SLOW_SUM,
        ST_RATIO,
        ST_DECIDE,
        ST_GAIN_MUL,
        ST_GAIN_ADD,
        ST_OUT_MUL,
        ST_OUT,
        ST_BYPASS
    } state_t;

    state_t                              state_reg,     state_next;
    logic [SB-1:0]                       sample_reg,    sample_next;
    logic [SB-1:0]                       mag_reg,       mag_next;
    logic                                neg_reg,       neg_next;
    logic [tsup_pkg::MUL_P_W-1:0]        acc_reg,       acc_next;
    logic [tsup_pkg::ENV_W-1:0]          fast_reg,      fast_next;
    logic [tsup_pkg::ENV_W-1:0]          slow_reg,      slow_next;
    logic [tsup_pkg::HOLD_W-1:0]         hold_reg,      hold_next;
    logic [tsup_pkg::GAIN_W-1:0]         gain_reg,      gain_next;
    logic [tsup_pkg::GAIN_W-1:0]         target_reg,    target_next;
    logic                                down_reg,      down_next;
    logic                                supp_reg,      supp_next;
    logic                                out_valid_reg, out_valid_next;
    logic [SB-1:0]                       out_data_reg,  out_data_next;
    logic                                out_supp_reg,  out_supp_next;

    logic [tsup_pkg::ENV_W-1:0]          mag8;
    logic [tsup_pkg::MUL_P_W-1:0]        env_sum;
    logic [tsup_pkg::MUL_P_W-1:0]        step_sum;
    logic [tsup_pkg::GAIN_W-1:0]         step;
    logic [tsup_pkg::GAIN_W-1:0]         atten;
    logic [tsup_pkg::GAIN_W-1:0]         diff;
    logic [tsup_pkg::COEF_W-1:0]         pole;
    logic                                near_zero;
    logic                                ratio_ok;
    logic                                trigger;
    logic [tsup_pkg::HOLD_W-1:0]         hold_load;
    logic [SB-1:0]                       scaled;
    logic                                out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_sample = out_data_reg;
    assign m_supp   = out_supp_reg;
    assign out_free = !out_valid_reg || m_ready;

    assign mag8     = {mag_reg, 8'b0};
    assign env_sum  = acc_reg + mul_prod;
    assign step_sum = mul_prod + tsup_pkg::ROUND_UP;
    assign step     = step_sum[tsup_pkg::FRAC_BITS +: tsup_pkg::GAIN_W];
    assign scaled   = mul_prod[tsup_pkg::FRAC_BITS +: SB];
    assign atten    = (cfg.attenuation_gain > tsup_pkg::UNITY_GAIN) ?
                      tsup_pkg::UNITY_GAIN : cfg.attenuation_gain;
    assign diff     = (target_reg < gain_reg) ? (gain_reg - target_reg)
                                              : (target_reg - gain_reg);
    assign pole     = (target_reg < gain_reg) ? tsup_pkg::ATTACK_COEFF : cfg.release_coeff;

    // Crest test on the fresh envelopes; the product holds threshold * slow.
    assign near_zero = (slow_reg <= tsup_pkg::SLOW_FLOOR) ||
                       ({fast_reg, 20'b0} <= tsup_pkg::CMP_W'(slow_reg));
    assign ratio_ok  = near_zero ? (cfg.threshold_ratio < tsup_pkg::THR_UNITY)
                                 : (tsup_pkg::MUL_P_W'({fast_reg, 8'b0}) > mul_prod);
    assign trigger   = ratio_ok &&
                       (tsup_pkg::CMP_W'(fast_reg) > tsup_pkg::CMP_W'({cfg.min_level, 8'b0}));
    assign hold_load = trigger ? cfg.hold_samples : hold_reg;

    always_comb begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        fast_next      = fast_reg;
        slow_next      = slow_reg;
        hold_next      = hold_reg;
        gain_next      = gain_reg;
        target_next    = target_reg;
        down_next      = down_reg;
        supp_next      = supp_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_supp_next  = out_supp_reg;
        mul_req        = '0;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (gain_unity) begin
            gain_next = tsup_pkg::UNITY_GAIN;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sample_next = s_sample;
                    neg_next    = s_sample[SB-1];
                    mag_next    = s_sample[SB-1] ? (SB'(0) - s_sample) : s_sample;
                    state_next  = cfg.enable ? ST_FAST_A : ST_BYPASS;
                end
            end
            ST_FAST_A: begin
                mul_req.issue = 1'b1;
                mul_req.a     = tsup_pkg::MUL_A_W'(cfg.fast_coeff);
                mul_req.b     = tsup_pkg::MUL_B_W'(fast_reg);
                state_next    = ST_FAST_B;
            end
            ST_FAST_B: begin
                mul_req.issue = 1'b1;
                mul_req.a     = tsup_pkg::UNITY_GAIN - tsup_pkg::MUL_A_W'(cfg.fast_coeff);
                mul_req.b     = tsup_pkg::MUL_B_W'(mag8);
                acc_next      = mul_prod;
                state_next    = ST_SLOW_A;
            end
            ST_SLOW_A: begin
                mul_req.issue = 1'b1;
                mul_req.a     = tsup_pkg::MUL_A_W'(cfg.slow_coeff);
                mul_req.b     = tsup_pkg::MUL_B_W'(slow_reg);
                fast_next     = env_sum[tsup_pkg::FRAC_BITS +: tsup_pkg::ENV_W];
                state_next    = ST_SLOW_B;
            end
            ST_SLOW_B: begin
                mul_req.issue = 1'b1;
                mul_req.a     = tsup_pkg::UNITY_GAIN - tsup_pkg::MUL_A_W'(cfg.slow_coeff);
                mul_req.b     = tsup_pkg::MUL_B_W'(mag8);
                acc_next      = mul_prod;
                state_next    = ST_SLOW_SUM;
            end
            ST_SLOW_SUM: begin
                slow_next  = env_sum[tsup_pkg::FRAC_BITS +: tsup_pkg::ENV_W];
                state_next = ST_RATIO;
            end
            ST_RATIO: begin
                mul_req.issue = 1'b1;
                mul_req.a     = tsup_pkg::MUL_A_W'(cfg.threshold_ratio);
                mul_req.b     = tsup_pkg::MUL_B_W'(slow_reg);
                state_next    = ST_DECIDE;
            end
            ST_DECIDE: begin
                // Reload on a transient, then count down one per sample.
                if (hold_load != '0) begin
                    hold_next   = hold_load - tsup_pkg::HOLD_W'(1);
                    target_next = atten;
                    supp_next   = 1'b1;
                end else begin
                    hold_next   = hold_load;
                    target_next = tsup_pkg::UNITY_GAIN;
                    supp_next   = 1'b0;
                end
                state_next = ST_GAIN_MUL;
            end
            ST_GAIN_MUL: begin
                mul_req.issue = 1'b1;
                mul_req.a     = tsup_pkg::UNITY_GAIN - tsup_pkg::MUL_A_W'(pole);
                mul_req.b     = tsup_pkg::MUL_B_W'(diff);
                down_next     = (target_reg < gain_reg);
                state_next    = ST_GAIN_ADD;
            end
            ST_GAIN_ADD: begin
                // Rounded-up step never exceeds the distance, so no overshoot.
                gain_next  = down_reg ? (gain_reg - step) : (gain_reg + step);
                state_next = ST_OUT_MUL;
            end
            ST_OUT_MUL: begin
                mul_req.issue = 1'b1;
                mul_req.a     = tsup_pkg::MUL_A_W'(gain_reg);
                mul_req.b     = tsup_pkg::MUL_B_W'(mag_reg);
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = neg_reg ? (SB'(0) - scaled) : scaled;
                    out_supp_next  = supp_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_BYPASS: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = sample_reg;
                    out_supp_next  = 1'b0;
                    gain_next      = tsup_pkg::UNITY_GAIN;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        acc_reg      <= acc_next;
        target_reg   <= target_next;
        down_reg     <= down_next;
        supp_reg     <= supp_next;
        out_data_reg <= out_data_next;
        out_supp_reg <= out_supp_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            fast_reg      <= '0;
            slow_reg      <= '0;
            hold_reg      <= '0;
            gain_reg      <= tsup_pkg::UNITY_GAIN;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            fast_reg      <= fast_next;
            slow_reg      <= slow_next;
            hold_reg      <= hold_next;
            gain_reg      <= gain_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/transient_suppressor.sv
// ----------------------------------------------------------------------------
// Transient suppressor
// Crest-factor transient suppressor for signed audio samples.
// ----------------------------------------------------------------------------
// The block takes one signed sample per request on the s_ stream and returns
// one sample per request on the m_ stream, scaled by a smoothed gain. A fast
// and a slow envelope of the magnitude are tracked; when the fast envelope is
// above min_level and fast/slow is above threshold_ratio, a hold counter is
// reloaded and the gain glides toward attenuation_gain, otherwise toward unity
// (attack pole fixed, release pole programmable). m_tuser flags samples taken
// while the hold counter ran. An enabled sample is processed between one
// acceptance and the next by one 17-bit by envelope-width multiplier that
// the sequencer reuses seven times per sample; a bypassed sample (enable low)
// skips the multiplier. A finished result waits in the output register, so
// the next request is accepted while the previous one is still pending; the
// sequencer only stalls on its last step if that register is still full.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module transient_suppressor (
    input  wire                                aclk,
    input  wire                                aresetn,
    // Input request: tdata = sample_in (signed) from bit 0
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [tsup_pkg::DATA_W-1:0]        s_tdata,
    // Result request: tdata = sample_out (signed) from bit 0
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [tsup_pkg::DATA_W-1:0]        m_tdata,
    // tuser = suppressing
    output logic                               m_tuser,
    // Configuration write channel
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [tsup_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [tsup_pkg::CFG_DATA_W-1:0]    cfg_data
);

    tsup_pkg::cfg_t                        cfg;
    tsup_pkg::mul_req_t                    mul_req;
    logic [tsup_pkg::MUL_P_W-1:0]          mul_prod;
    logic                                  gain_unity;
    logic [tsup_pkg::SAMPLE_BITS-1:0]      out_sample;

    // Registers accept a write on every cycle.
    assign cfg_ready = 1'b1;

    // Zero-fill the result up to whole bytes.
    assign m_tdata = tsup_pkg::DATA_W'(out_sample);

    tsup_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .gain_unity (gain_unity)
    );

    tsup_mul u_mul (
        .aclk     (aclk),
        .req      (mul_req),
        .prod_reg (mul_prod)
    );

    tsup_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .gain_unity (gain_unity),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_sample   (s_tdata[tsup_pkg::SAMPLE_BITS-1:0]),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_sample   (out_sample),
        .m_supp     (m_tuser),
        .mul_req    (mul_req),
        .mul_prod   (mul_prod)
    );

endmodule

`default_nettype wire

FILE: rtl/tsup_checker.sv
// ----------------------------------------------------------------------------
// Transient suppressor port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "transient_suppressor_macros.svh"

module tsup_checker (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    input  wire                            s_tready,
    input  wire                            m_tvalid,
    input  wire                            m_tready,
    input  wire [tsup_pkg::DATA_W-1:0]     m_tdata,
    input  wire                            m_tuser
);

    // A stalled result holds its payload.
    `TSUP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // A result is only withdrawn after it was taken.
    `TSUP_ASSERT_SAME(a_out_taken, $fell(m_tvalid) && $past(aresetn), $past(m_tready), "result dropped without handshake")

    // One sample at a time: busy right after an accepted request.
    `TSUP_ASSERT_NEXT(a_in_busy, s_tvalid && s_tready, !s_tready, "request accepted while busy")

    // A new result appears only as the sequencer returns to idle.
    `TSUP_ASSERT_SAME(a_out_at_end, $rose(m_tvalid) && $past(aresetn), s_tready, "result issued mid-sample")

endmodule

bind transient_suppressor tsup_checker u_tsup_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_transient_suppressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient suppressor testbench
// Streams signed samples into the suppressor and compares every returned
// sample and suppression flag with a cycle-free prediction of the block, over
// directed corner cases and randomized transient-shaped traffic.
// ----------------------------------------------------------------------------

module tb_transient_suppressor;

    import tsup_pkg::*;

    // Hard stop for a hung run, in clock cycles
    localparam int CYCLE_LIMIT = 500000;
    // Cycles to keep watching the result stream after the last expected sample
    localparam int TAIL_CYCLES = 48;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 100;

    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic              suppressing;
    } out_sample_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;     // sample_in (signed) from bit 0
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;            // sample_out (signed) from bit 0
    logic                  m_tuser;            // suppressing
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    transient_suppressor uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Clock and run guard
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    int unsigned cycle_count = 0;

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow of the block: register file and suppressor state
    // ------------------------------------------------------------------------
    cfg_t        regs;
    logic [63:0] env_fast;
    logic [63:0] env_slow;
    logic [19:0] hold_left;
    logic [31:0] gain_now;

    // Samples predicted for requests already accepted, oldest first
    out_sample_t expected_samples[$];
    int unsigned error_count = 0;

    task automatic reset_shadow();
        regs.enable           = 1'b1;
        regs.fast_coeff       = 16'd64185;
        regs.slow_coeff       = 16'd65522;
        regs.release_coeff    = 16'd65522;
        regs.hold_samples     = 20'd0;
        regs.threshold_ratio  = 16'd1019;
        regs.min_level        = 23'd8389;
        regs.attenuation_gain = 17'd16462;
        env_fast  = '0;
        env_slow  = '0;
        hold_left = '0;
        gain_now  = 32'(UNITY_GAIN);
    endtask

    // One-pole smoother: floor((c*env + (1-c)*mag) / 65536)
    function automatic logic [63:0] envelope_next(input logic [63:0] env,
                                                  input logic [15:0] pole,
                                                  input logic [63:0] mag8);
        logic [63:0] cc;
        cc = 64'(pole);
        return (cc * env + (64'd65536 - cc) * mag8) >> 16;
    endfunction

    // Move the gain toward the goal by a rounded-up step so it always lands
    function automatic logic [31:0] gain_next(input logic [31:0] gain,
                                              input logic [31:0] goal,
                                              input logic [15:0] pole);
        logic [63:0] w;
        logic [63:0] d;
        logic [63:0] stride;
        w = 64'd65536 - 64'(pole);
        if (goal < gain) begin
            d = 64'(gain - goal);
            stride = (w * d + 64'd65535) >> 16;
            return gain - stride[31:0];
        end
        d = 64'(goal - gain);
        stride = (w * d + 64'd65535) >> 16;
        return gain + stride[31:0];
    endfunction

    // Advance the shadow state by one sample and return the sample it yields
    function automatic out_sample_t suppress_sample(input logic [DATA_W-1:0] raw);
        out_sample_t res;
        logic        neg;
        logic [63:0] mag;
        logic [63:0] prod;
        logic        crest_hit;
        logic [31:0] goal;
        neg = raw[SAMPLE_BITS-1];
        mag = neg ? ((64'd1 << SAMPLE_BITS) - 64'(raw)) : 64'(raw);
        res.sample      = raw;
        res.suppressing = 1'b0;
        if (!regs.enable) begin
            gain_now = 32'(UNITY_GAIN);
            return res;
        end
        env_fast = envelope_next(env_fast, regs.fast_coeff, mag << 8);
        env_slow = envelope_next(env_slow, regs.slow_coeff, mag << 8);
        // Slow envelope near silence, or fast far below slow: crest counts as one
        if (env_slow <= 64'(SLOW_FLOOR) || (env_fast << 20) <= env_slow)
            crest_hit = THR_UNITY > regs.threshold_ratio;
        else
            crest_hit = (env_fast << 8) > (64'(regs.threshold_ratio) * env_slow);
        if (env_fast > (64'(regs.min_level) << 8) && crest_hit)
            hold_left = regs.hold_samples;
        goal = 32'(UNITY_GAIN);
        if (hold_left != 0) begin
            // Attenuation above unity saturates at unity
            goal = (regs.attenuation_gain > UNITY_GAIN) ? 32'(UNITY_GAIN)
                                                        : 32'(regs.attenuation_gain);
            hold_left--;
            res.suppressing = 1'b1;
        end
        if (goal < gain_now)
            gain_now = gain_next(gain_now, goal, ATTACK_COEFF);
        else
            gain_now = gain_next(gain_now, goal, regs.release_coeff);
        prod = (mag * 64'(gain_now)) >> 16;
        if (neg)
            prod = (64'd1 << SAMPLE_BITS) - prod;
        res.sample = prod[DATA_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: stall pattern and compare each returned request
    // ------------------------------------------------------------------------
    out_sample_t oldest;
    int unsigned rx_mode  = 0;
    int unsigned rx_left  = 0;
    int unsigned rx_phase = 0;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected result: sample_out %0d, suppressing %0b",
                       $signed(m_tdata), m_tuser);
                error_count++;
            end else begin
                oldest = expected_samples.pop_front();
                if (m_tdata !== oldest.sample) begin
                    $error("sample_out: expected %0d, actual %0d",
                           $signed(oldest.sample), $signed(m_tdata));
                    error_count++;
                end
                if (m_tuser !== oldest.suppressing) begin
                    $error("suppressing: expected %0b, actual %0b",
                           oldest.suppressing, m_tuser);
                    error_count++;
                end
            end
        end

        // Pick a new stall pattern every so often; mode 0 never stalls
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        rx_phase++;
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
                m_tready <= ((rx_phase % 5) < 2);
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    int unsigned burst_left = 0;

    // Offer one sample and hold it until accepted; valid stays high afterward
    task automatic send_sample(input logic [DATA_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        expected_samples.push_back(suppress_sample(value));
    endtask

    // Send in bursts; drop valid for a random gap when a burst runs out
    task automatic stream_sample(input logic [DATA_W-1:0] value);
        send_sample(value);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Drop valid and wait until every predicted sample has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_samples.size() != 0) @(posedge aclk);
    endtask

    // Write one register and mirror it into the shadow at the same edge
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            REG_ENABLE: begin
                regs.enable = value[0];
                // Leaving suppression snaps the gain back to unity
                if (!value[0])
                    gain_now = 32'(UNITY_GAIN);
            end
            REG_FAST_COEF: regs.fast_coeff       = value[COEF_W-1:0];
            REG_SLOW_COEF: regs.slow_coeff       = value[COEF_W-1:0];
            REG_REL_COEF:  regs.release_coeff    = value[COEF_W-1:0];
            REG_HOLD:      regs.hold_samples     = value[HOLD_W-1:0];
            REG_THRESHOLD: regs.threshold_ratio  = value[THR_W-1:0];
            REG_MIN_LEVEL: regs.min_level        = value[MINLVL_W-1:0];
            REG_ATTEN:     regs.attenuation_gain = value[GAIN_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_all(input cfg_t c);
        write_register(REG_ENABLE,    CFG_DATA_W'(c.enable));
        write_register(REG_FAST_COEF, CFG_DATA_W'(c.fast_coeff));
        write_register(REG_SLOW_COEF, CFG_DATA_W'(c.slow_coeff));
        write_register(REG_REL_COEF,  CFG_DATA_W'(c.release_coeff));
        write_register(REG_HOLD,      CFG_DATA_W'(c.hold_samples));
        write_register(REG_THRESHOLD, CFG_DATA_W'(c.threshold_ratio));
        write_register(REG_MIN_LEVEL, CFG_DATA_W'(c.min_level));
        write_register(REG_ATTEN,     CFG_DATA_W'(c.attenuation_gain));
    endtask

    function automatic cfg_t random_settings();
        cfg_t c;
        c.enable = ($urandom_range(0, 7) != 0);
        c.fast_coeff = $urandom_range(0, 1) ? 16'($urandom_range(60000, 65535))
                                            : 16'($urandom());
        c.slow_coeff = $urandom_range(0, 1) ? 16'($urandom_range(65000, 65535))
                                            : 16'($urandom());
        c.release_coeff = $urandom_range(0, 1) ? 16'($urandom_range(64000, 65535))
                                               : 16'($urandom());
        case ($urandom_range(0, 3))
            0:       c.hold_samples = '0;
            1:       c.hold_samples = 20'($urandom_range(1, 64));
            2:       c.hold_samples = 20'($urandom_range(1, 2000));
            default: c.hold_samples = 20'($urandom());
        endcase
        case ($urandom_range(0, 3))
            0:       c.threshold_ratio = 16'($urandom_range(0, 255));
            1:       c.threshold_ratio = 16'($urandom());
            default: c.threshold_ratio = 16'($urandom_range(256, 2048));
        endcase
        c.min_level = $urandom_range(0, 1) ? 23'($urandom_range(0, 65535))
                                           : 23'($urandom());
        c.attenuation_gain = 17'($urandom_range(0, 131071));
        return c;
    endfunction

    // Signed sample of a given magnitude with a random sign
    function automatic logic [DATA_W-1:0] signed_sample(input int unsigned mag);
        logic [DATA_W-1:0] v;
        v = DATA_W'(mag);
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: zero hold means a trigger never attenuates
    task automatic test_reset_values();
        send_sample(24'sd0);
        send_sample(24'sd1);
        send_sample(24'sd8388607);
        send_sample(-24'sd8388608);
        send_sample(-24'sd1);
        wait_drained();
    endtask

    // Bypass passes samples untouched and freezes the envelopes
    task automatic test_bypass();
        write_register(REG_ENABLE, '0);
        send_sample(24'sd0);
        send_sample(24'sd8388607);
        send_sample(-24'sd8388608);
        send_sample(-24'sd1);
        wait_drained();
        write_register(REG_ENABLE, CFG_DATA_W'(1));
    endtask

    // Near-silent slow envelope: crest counts as one, so threshold decides
    task automatic test_slow_floor();
        write_register(REG_FAST_COEF, '0);
        write_register(REG_SLOW_COEF, '0);
        write_register(REG_MIN_LEVEL, '0);
        write_register(REG_THRESHOLD, '0);
        write_register(REG_HOLD, CFG_DATA_W'(3));
        send_sample(24'sd5);
        send_sample(-24'sd7);
        send_sample(24'sd3);
        wait_drained();
        // At exactly unity the crest test must fail
        write_register(REG_THRESHOLD, CFG_DATA_W'(256));
        send_sample(24'sd4);
        send_sample(-24'sd4);
        wait_drained();
    endtask

    // Fast envelope tiny against a loud slow one: crest also counts as one
    task automatic test_ratio_floor();
        write_register(REG_THRESHOLD, '0);
        send_sample(24'sd8388607);
        wait_drained();
        write_register(REG_SLOW_COEF, CFG_DATA_W'(65535));
        send_sample(24'sd1);
        send_sample(-24'sd1);
        wait_drained();
    endtask

    // Attenuation above unity saturates; zero attenuation and release extremes
    task automatic test_attenuation_limits();
        write_register(REG_ATTEN, CFG_DATA_W'(131071));
        write_register(REG_HOLD, CFG_DATA_W'(1048575));
        write_register(REG_REL_COEF, '0);
        send_sample(-24'sd8388608);
        send_sample(24'sd8388607);
        wait_drained();
        write_register(REG_ATTEN, '0);
        write_register(REG_REL_COEF, CFG_DATA_W'(65535));
        send_sample(24'sd8388607);
        send_sample(-24'sd8388608);
        send_sample(24'sd1234567);
        wait_drained();
        // Every sample now reloads the hold with zero, so the gain releases at once
        write_register(REG_HOLD, '0);
        write_register(REG_REL_COEF, '0);
        send_sample(24'sd8388607);
        send_sample(-24'sd2000000);
        wait_drained();
    endtask

    // Phases of transient-shaped traffic under varied register settings
    task automatic test_random_program();
        cfg_t        c;
        int unsigned quiet_left;
        int unsigned spike_left;
        logic [DATA_W-1:0] x;
        quiet_left = 0;
        spike_left = 0;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                c = '0;
                c.enable = 1'b1;
            end else if (p == 1) begin
                c.enable           = 1'b1;
                c.fast_coeff       = 16'hFFFF;
                c.slow_coeff       = 16'hFFFF;
                c.release_coeff    = 16'hFFFF;
                c.hold_samples     = 20'hFFFFF;
                c.threshold_ratio  = 16'hFFFF;
                c.min_level        = 23'h7FFFFF;
                c.attenuation_gain = 17'h1FFFF;
            end else begin
                c = random_settings();
            end
            wait_drained();
            program_all(c);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 9) < 2) begin
                    // noise across the whole range
                    x = DATA_W'($urandom());
                end else if (spike_left != 0) begin
                    x = signed_sample($urandom_range(1 << 18, 8388607));
                    spike_left--;
                end else begin
                    x = signed_sample($urandom_range(0, 1 << $urandom_range(2, 12)));
                    if (quiet_left == 0) begin
                        spike_left = $urandom_range(1, 6);
                        quiet_left = $urandom_range(8, 60);
                    end else begin
                        quiet_left--;
                    end
                end
                stream_sample(x);
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_shadow();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_bypass();
        test_slow_floor();
        test_ratio_floor();
        test_attenuation_limits();
        test_random_program();

        // Keep watching for stray results before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tsup_pkg.sv
rtl/tsup_mul.sv
rtl/tsup_cfg.sv
rtl/tsup_core.sv
rtl/transient_suppressor.sv
rtl/tsup_checker.sv
tb/sv/tb_transient_suppressor.sv
